FILE: rtl/price_level_order_book_macros.svh
// assertion macros for the price level order book
`ifndef PRICE_LEVEL_ORDER_BOOK_MACROS_SVH
`define PRICE_LEVEL_ORDER_BOOK_MACROS_SVH

// same-cycle implication, checked outside reset
`define PLB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plb assertion failed");

// next-cycle implication, checked outside reset
`define PLB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plb assertion failed");

`endif

FILE: rtl/plb_pkg.sv
// shared types and constants of the price level order book
`default_nettype none
package plb_pkg;

  localparam int DEPTH_DEF      = 32;
  localparam int PRICE_BITS_DEF = 48;
  localparam int SIZE_BITS_DEF  = 48;
  localparam int MAX_ROWS       = 32;

  localparam logic [2:0] MODE_SET    = 3'd0;
  localparam logic [2:0] MODE_CHANGE = 3'd1;
  localparam logic [2:0] MODE_DELETE = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EVICTED  = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_ROW      = 3'd4;

  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  // command broadcast to every cell of one side
  typedef struct packed {
    logic set;
    logic del;
    logic clr;
    logic ask;
  } cell_op_t;

  // side summary back to the controller
  typedef struct packed {
    logic hit;
    logic full;
    logic evict;
  } side_res_t;

endpackage
`default_nettype wire

FILE: rtl/plb_cell.sv
// one price level cell of a sorted side chain
`default_nettype none
module plb_cell import plb_pkg::*; #(
  parameter int PRICE_BITS = PRICE_BITS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cell_op_t              op,
  input  wire logic                  hit,
  input  wire logic [PRICE_BITS-1:0] new_price,
  input  wire logic [SIZE_BITS-1:0]  new_size,
  input  wire logic                  l_valid,
  input  wire logic [PRICE_BITS-1:0] l_price,
  input  wire logic [SIZE_BITS-1:0]  l_size,
  input  wire logic                  l_better,
  input  wire logic                  l_seen,
  input  wire logic                  r_valid,
  input  wire logic [PRICE_BITS-1:0] r_price,
  input  wire logic [SIZE_BITS-1:0]  r_size,
  output logic                       valid,
  output logic [PRICE_BITS-1:0]      price,
  output logic [SIZE_BITS-1:0]       size,
  output logic                       better,
  output logic                       match,
  output logic                       seen
);

  logic                  valid_r, valid_nxt;
  logic [PRICE_BITS-1:0] price_r, price_nxt;
  logic [SIZE_BITS-1:0]  size_r, size_nxt;

  assign valid  = valid_r & ~op.clr;
  assign price  = price_r;
  assign size   = size_r;
  assign match  = valid && (price_r == new_price);
  assign better = !valid || (op.ask ? (new_price < price_r) : (new_price > price_r));
  assign seen   = l_seen | match;

  always_comb begin
    valid_nxt = valid;
    price_nxt = price_r;
    size_nxt  = size_r;
    if (op.set) begin
      if (hit) begin
        if (match) size_nxt = new_size;
      end else if (better) begin
        if (l_better) begin
          valid_nxt = l_valid;
          price_nxt = l_price;
          size_nxt  = l_size;
        end else begin
          valid_nxt = 1'b1;
          price_nxt = new_price;
          size_nxt  = new_size;
        end
      end
    end else if (op.del && seen) begin
      valid_nxt = r_valid;
      price_nxt = r_price;
      size_nxt  = r_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    price_r <= price_nxt;
    size_r  <= size_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/plb_side.sv
// one side of the book: a sorted chain of level cells, best first
`default_nettype none
module plb_side import plb_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire cell_op_t                         op,
  input  wire logic [PRICE_BITS-1:0]            new_price,
  input  wire logic [SIZE_BITS-1:0]             new_size,
  output logic [DEPTH-1:0]                      vld,
  output logic [DEPTH-1:0][PRICE_BITS-1:0]      px,
  output logic [DEPTH-1:0][SIZE_BITS-1:0]       sz,
  output side_res_t                             res
);

  logic [DEPTH-1:0] better, match, seen;
  logic             hit;

  assign hit       = |match;
  assign res.hit   = hit;
  assign res.full  = vld[DEPTH-1];
  assign res.evict = better[DEPTH-1];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  lv, lb, ls, rv;
    logic [PRICE_BITS-1:0] lp, rp;
    logic [SIZE_BITS-1:0]  lz, rz;

    if (i == 0) begin : g_head
      assign lv = 1'b0;
      assign lp = '0;
      assign lz = '0;
      assign lb = 1'b0;
      assign ls = 1'b0;
    end else begin : g_mid
      assign lv = vld[i-1];
      assign lp = px[i-1];
      assign lz = sz[i-1];
      assign lb = better[i-1];
      assign ls = seen[i-1];
    end

    if (i == DEPTH-1) begin : g_tail
      assign rv = 1'b0;
      assign rp = '0;
      assign rz = '0;
    end else begin : g_body
      assign rv = vld[i+1];
      assign rp = px[i+1];
      assign rz = sz[i+1];
    end

    plb_cell #(.PRICE_BITS(PRICE_BITS), .SIZE_BITS(SIZE_BITS)) u_cell (
      .clk(clk), .rst_n(rst_n), .op(op), .hit(hit),
      .new_price(new_price), .new_size(new_size),
      .l_valid(lv), .l_price(lp), .l_size(lz), .l_better(lb), .l_seen(ls),
      .r_valid(rv), .r_price(rp), .r_size(rz),
      .valid(vld[i]), .price(px[i]), .size(sz[i]),
      .better(better[i]), .match(match[i]), .seen(seen[i])
    );
  end

endmodule
`default_nettype wire

FILE: rtl/price_level_order_book.sv
// top level of the price level order book: command control, two cell chains, result register
//
//   channel  | ports                                            | direction
//   ---------+--------------------------------------------------+----------
//   input    | in_valid in_stall in_mode in_side in_price       | in
//            | in_quantity in_clear_first                       |
//   result   | out_valid out_stall out_status out_row_index     | out
//            | out_bid_* out_ask_* out_last                     |
//
// an edit is accepted, then every cell of the side compares and shifts at once
// the result register loads at the compare edge; the next transfer in can be taken at the
// same edge as the last result transfer out
// a read out sends one result per row, rows = max(bid count, ask count), at least 1, at most 32
// rst_n clears the controller, the level counts and the cell valid bits; no clearing pass
// out_stall holds the current row; the book stays put
`default_nettype none
`include "price_level_order_book_macros.svh"
module price_level_order_book import plb_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [2:0]            in_mode,
  input  wire logic                  in_side,
  input  wire logic [PRICE_BITS-1:0] in_price,
  input  wire logic [SIZE_BITS-1:0]  in_quantity,
  input  wire logic                  in_clear_first,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [2:0]                 out_status,
  output logic [4:0]                 out_row_index,
  output logic                       out_bid_valid,
  output logic [PRICE_BITS-1:0]      out_bid_price,
  output logic [SIZE_BITS-1:0]       out_bid_size,
  output logic                       out_ask_valid,
  output logic [PRICE_BITS-1:0]      out_ask_price,
  output logic [SIZE_BITS-1:0]       out_ask_size,
  output logic                       out_last
);

  localparam int IDXW   = $clog2(DEPTH);
  localparam int CNTW   = $clog2(DEPTH+1);
  localparam int ROWCAP = (DEPTH < MAX_ROWS) ? DEPTH : MAX_ROWS;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SEND = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // accepted command
  logic [2:0]            cmd_mode_r;
  logic                  cmd_side_r;
  logic [PRICE_BITS-1:0] cmd_price_r;
  logic [SIZE_BITS-1:0]  cmd_size_r;
  logic                  cmd_clr_r;

  logic [CNTW-1:0] bid_cnt_r, bid_cnt_nxt, ask_cnt_r, ask_cnt_nxt;
  logic [IDXW-1:0] row_r, row_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic [2:0]            status_r, status_nxt;
  logic [4:0]            rix_r, rix_nxt;
  logic                  bv_r, bv_nxt, av_r, av_nxt, last_r, last_nxt;
  logic [PRICE_BITS-1:0] bp_r, bp_nxt, ap_r, ap_nxt;
  logic [SIZE_BITS-1:0]  bs_r, bs_nxt, as_r, as_nxt;

  cell_op_t  bid_op, ask_op;
  side_res_t bid_res, ask_res, sel_res;

  logic [DEPTH-1:0]                 bid_vld, ask_vld;
  logic [DEPTH-1:0][PRICE_BITS-1:0] bid_px, ask_px;
  logic [DEPTH-1:0][SIZE_BITS-1:0]  bid_sz, ask_sz;

  logic in_xfer, out_xfer, exec, is_set, is_read;
  logic [CNTW-1:0] max_cnt, rows, base_cnt, edit_cnt;
  logic [IDXW-1:0] idx;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign exec     = (state_r == S_EXEC);
  // open in idle, and while sending, at the edge where the last result leaves
  assign in_stall = exec || ((state_r == S_SEND) && !(out_xfer && last_r));
  assign is_set   = (cmd_mode_r == MODE_SET) || (cmd_mode_r == MODE_CHANGE);
  assign is_read  = (cmd_mode_r == MODE_READ);

  // per side broadcast: clear_first wipes the side in the same cycle as the insert
  always_comb begin
    bid_op.ask = SIDE_BID;
    ask_op.ask = SIDE_ASK;
    bid_op.set = exec && is_set && (cmd_side_r == SIDE_BID);
    ask_op.set = exec && is_set && (cmd_side_r == SIDE_ASK);
    bid_op.del = exec && (cmd_mode_r == MODE_DELETE) && (cmd_side_r == SIDE_BID);
    ask_op.del = exec && (cmd_mode_r == MODE_DELETE) && (cmd_side_r == SIDE_ASK);
    bid_op.clr = exec && ((cmd_mode_r == MODE_CLEAR) ||
                 ((cmd_mode_r == MODE_CHANGE) && cmd_clr_r && (cmd_side_r == SIDE_BID)));
    ask_op.clr = exec && ((cmd_mode_r == MODE_CLEAR) ||
                 ((cmd_mode_r == MODE_CHANGE) && cmd_clr_r && (cmd_side_r == SIDE_ASK)));
  end

  plb_side #(.DEPTH(DEPTH), .PRICE_BITS(PRICE_BITS), .SIZE_BITS(SIZE_BITS)) u_bid (
    .clk(clk), .rst_n(rst_n), .op(bid_op), .new_price(cmd_price_r), .new_size(cmd_size_r),
    .vld(bid_vld), .px(bid_px), .sz(bid_sz), .res(bid_res)
  );

  plb_side #(.DEPTH(DEPTH), .PRICE_BITS(PRICE_BITS), .SIZE_BITS(SIZE_BITS)) u_ask (
    .clk(clk), .rst_n(rst_n), .op(ask_op), .new_price(cmd_price_r), .new_size(cmd_size_r),
    .vld(ask_vld), .px(ask_px), .sz(ask_sz), .res(ask_res)
  );

  assign sel_res = (cmd_side_r == SIDE_ASK) ? ask_res : bid_res;

  // level count of the edited side after this command
  assign base_cnt = (cmd_mode_r == MODE_CHANGE && cmd_clr_r) ? '0 :
                    ((cmd_side_r == SIDE_ASK) ? ask_cnt_r : bid_cnt_r);
  always_comb begin
    edit_cnt = base_cnt;
    if (is_set) begin
      if (!sel_res.hit && !sel_res.full) edit_cnt = base_cnt + CNTW'(1);
    end else if (cmd_mode_r == MODE_DELETE) begin
      if (sel_res.hit) edit_cnt = base_cnt - CNTW'(1);
    end
  end

  // read-out row count, capped and never zero so a last row always goes out
  assign max_cnt = (bid_cnt_r > ask_cnt_r) ? bid_cnt_r : ask_cnt_r;
  always_comb begin
    rows = (max_cnt > CNTW'(ROWCAP)) ? CNTW'(ROWCAP) : max_cnt;
    if (rows == '0) rows = CNTW'(1);
  end

  assign idx = exec ? '0 : row_r + IDXW'(1);

  always_comb begin
    state_nxt     = state_r;
    bid_cnt_nxt   = bid_cnt_r;
    ask_cnt_nxt   = ask_cnt_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    rix_nxt       = rix_r;
    bv_nxt        = bv_r;
    bp_nxt        = bp_r;
    bs_nxt        = bs_r;
    av_nxt        = av_r;
    ap_nxt        = ap_r;
    as_nxt        = as_r;
    last_nxt      = last_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (is_read || is_set || cmd_mode_r == MODE_DELETE || cmd_mode_r == MODE_CLEAR) begin
          state_nxt     = S_SEND;
          out_valid_nxt = 1'b1;
        end else begin
          state_nxt = S_IDLE;  // undefined mode: no result
        end
        if (!is_read) begin
          status_nxt = ST_OK;
          rix_nxt    = '0;
          bv_nxt     = 1'b0;
          bp_nxt     = '0;
          bs_nxt     = '0;
          av_nxt     = 1'b0;
          ap_nxt     = '0;
          as_nxt     = '0;
          last_nxt   = 1'b1;
          if (cmd_mode_r == MODE_CLEAR) begin
            bid_cnt_nxt = '0;
            ask_cnt_nxt = '0;
          end else if (is_set || cmd_mode_r == MODE_DELETE) begin
            if (cmd_side_r == SIDE_ASK) ask_cnt_nxt = edit_cnt;
            else                        bid_cnt_nxt = edit_cnt;
          end
          if (is_set && !sel_res.hit && sel_res.full)
            status_nxt = sel_res.evict ? ST_EVICTED : ST_DROPPED;
          else if (cmd_mode_r == MODE_DELETE && !sel_res.hit)
            status_nxt = ST_NOTFOUND;
        end
      end
      S_SEND: begin
        if (out_xfer) begin
          if (last_r) begin
            // a transfer in at this edge goes straight to compare
            state_nxt     = in_xfer ? S_EXEC : S_IDLE;
            out_valid_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // load a read-out row on entry and after each row transfer
    if ((exec && is_read) || (state_r == S_SEND && out_xfer && !last_r)) begin
      row_nxt    = idx;
      status_nxt = ST_ROW;
      rix_nxt    = 5'(idx);
      bv_nxt     = bid_vld[idx];
      bp_nxt     = bid_vld[idx] ? bid_px[idx] : '0;
      bs_nxt     = bid_vld[idx] ? bid_sz[idx] : '0;
      av_nxt     = ask_vld[idx];
      ap_nxt     = ask_vld[idx] ? ask_px[idx] : '0;
      as_nxt     = ask_vld[idx] ? ask_sz[idx] : '0;
      last_nxt   = ((CNTW'(idx) + CNTW'(1)) == rows);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bid_cnt_r   <= '0;
      ask_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bid_cnt_r   <= bid_cnt_nxt;
      ask_cnt_r   <= ask_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_mode_r  <= in_mode;
      cmd_side_r  <= in_side;
      cmd_price_r <= in_price;
      cmd_size_r  <= in_quantity;
      cmd_clr_r   <= in_clear_first;
    end
    row_r    <= row_nxt;
    status_r <= status_nxt;
    rix_r    <= rix_nxt;
    bv_r     <= bv_nxt;
    bp_r     <= bp_nxt;
    bs_r     <= bs_nxt;
    av_r     <= av_nxt;
    ap_r     <= ap_nxt;
    as_r     <= as_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_row_index = rix_r;
  assign out_bid_valid = bv_r;
  assign out_bid_price = bp_r;
  assign out_bid_size  = bs_r;
  assign out_ask_valid = av_r;
  assign out_ask_price = ap_r;
  assign out_ask_size  = as_r;
  assign out_last      = last_r;

  // level counts track the cell valid bits outside the compare cycle (clear masks them)
  `PLB_ASSERT_IMPL(a_bid_cnt, !exec, CNTW'($countones(bid_vld)) == bid_cnt_r)
  `PLB_ASSERT_IMPL(a_ask_cnt, !exec, CNTW'($countones(ask_vld)) == ask_cnt_r)
  // edit results are always single
  `PLB_ASSERT_IMPL(a_edit_last, out_valid_r && status_r != ST_ROW, last_r)
  // a transfer in always starts the compare cycle
  `PLB_ASSERT_NEXT(a_exec, in_xfer, state_r == S_EXEC)

endmodule
`default_nettype wire

FILE: tb/price_level_order_book_tb.sv
// self-checking testbench for the price level order book: random edits and read outs
`default_nettype none
module price_level_order_book_tb import plb_pkg::*;;

  localparam int NLVL = 32;

  typedef struct packed {
    logic [2:0]  mode;
    logic        side;
    logic [47:0] price;
    logic [47:0] qty;
    logic        clr;
  } book_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  row;
    logic        bv;
    logic [47:0] bp;
    logic [47:0] bs;
    logic        av;
    logic [47:0] ap;
    logic [47:0] as_;
    logic        last;
  } book_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_mode = '0;
  logic in_side = 1'b0;
  logic [47:0] in_price = '0;
  logic [47:0] in_quantity = '0;
  logic in_clear_first = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic [4:0] out_row_index;
  logic out_bid_valid, out_ask_valid, out_last;
  logic [47:0] out_bid_price, out_bid_size, out_ask_price, out_ask_size;

  price_level_order_book dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the book
  logic [47:0] bid_px [NLVL];
  logic [47:0] bid_sz [NLVL];
  logic [47:0] ask_px [NLVL];
  logic [47:0] ask_sz [NLVL];
  int bid_n = 0;
  int ask_n = 0;

  book_cmd_t pending_cmds[$];
  book_row_t expected_rows[$];
  int errors = 0;
  bit hold_for_drain = 0;

  // append to the tail of the pending and expected queues
  task automatic queue_cmd(book_cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic queue_row(book_row_t r);
    expected_rows.insert(expected_rows.size(), r);
  endtask

  function automatic bit beats(logic sd, logic [47:0] a, logic [47:0] b);
    return sd == SIDE_BID ? (a > b) : (a < b);
  endfunction

  // insert or overwrite a level, returns the status
  function automatic logic [2:0] put_level(logic sd, logic [47:0] px, logic [47:0] sz);
    logic [47:0] p [NLVL];
    logic [47:0] s [NLVL];
    int n, pos;
    logic [2:0] st;
    st = ST_OK;
    if (sd) begin
      p = ask_px;
      s = ask_sz;
      n = ask_n;
    end else begin
      p = bid_px;
      s = bid_sz;
      n = bid_n;
    end
    pos = n;
    for (int i = 0; i < n; i++)
      if (p[i] == px) begin
        s[i] = sz;
        if (sd) ask_sz = s; else bid_sz = s;
        return ST_OK;
      end
    for (int i = n - 1; i >= 0; i--)
      if (beats(sd, px, p[i])) pos = i;
    if (n >= NLVL) begin
      if (pos >= NLVL) return ST_DROPPED;
      n = NLVL - 1;
      st = ST_EVICTED;
    end
    for (int i = n; i > pos; i--) begin
      p[i] = p[i-1];
      s[i] = s[i-1];
    end
    p[pos] = px;
    s[pos] = sz;
    if (sd) begin ask_px = p; ask_sz = s; ask_n = n + 1; end
    else begin bid_px = p; bid_sz = s; bid_n = n + 1; end
    return st;
  endfunction

  function automatic logic [2:0] drop_level(logic sd, logic [47:0] px);
    int n;
    n = sd ? ask_n : bid_n;
    for (int i = 0; i < n; i++) begin
      if ((sd ? ask_px[i] : bid_px[i]) == px) begin
        for (int j = i; j + 1 < n; j++)
          if (sd) begin ask_px[j] = ask_px[j+1]; ask_sz[j] = ask_sz[j+1]; end
          else begin bid_px[j] = bid_px[j+1]; bid_sz[j] = bid_sz[j+1]; end
        if (sd) ask_n = n - 1; else bid_n = n - 1;
        return ST_OK;
      end
    end
    return ST_NOTFOUND;
  endfunction

  // apply one accepted transfer to the shadow book and queue its rows
  task automatic apply_cmd(book_cmd_t c);
    book_row_t r;
    int rows;
    r = '0;
    r.last = 1'b1;
    case (c.mode)
      MODE_SET: r.status = put_level(c.side, c.price, c.qty);
      MODE_CHANGE: begin
        if (c.clr) begin
          if (c.side) ask_n = 0; else bid_n = 0;
        end
        r.status = put_level(c.side, c.price, c.qty);
      end
      MODE_DELETE: r.status = drop_level(c.side, c.price);
      MODE_CLEAR: begin
        bid_n = 0;
        ask_n = 0;
        r.status = ST_OK;
      end
      MODE_READ: begin
        rows = bid_n > ask_n ? bid_n : ask_n;
        if (rows == 0) rows = 1;
        for (int i = 0; i < rows; i++) begin
          r = '0;
          r.status = ST_ROW;
          r.row = i[4:0];
          r.bv = i < bid_n;
          r.av = i < ask_n;
          if (r.bv) begin r.bp = bid_px[i]; r.bs = bid_sz[i]; end
          if (r.av) begin r.ap = ask_px[i]; r.as_ = ask_sz[i]; end
          r.last = i == rows - 1;
          queue_row(r);
        end
      end
      default: ; // undefined modes produce nothing
    endcase
    if (c.mode inside {MODE_SET, MODE_CHANGE, MODE_DELETE, MODE_CLEAR})
      queue_row(r);
  endtask

  task automatic report(string what, logic [47:0] got, logic [47:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // driver: bursts with random gaps, ports driven with nonblocking assignments
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    book_cmd_t c;
    if (rst_n) begin
      if (in_valid && !in_stall) apply_cmd({in_mode, in_side, in_price, in_quantity,
                                           in_clear_first});
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || pending_cmds.size() == 0 ||
            (hold_for_drain && pending_cmds[0].mode === 3'bx)) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else if (hold_for_drain && (expected_rows.size() != 0 ||
                     (in_valid && !in_stall))) begin
          in_valid <= 1'b0;
        end else begin
          hold_for_drain = 0;
          c = pending_cmds.pop_front();
          in_valid <= 1'b1;
          {in_mode, in_side, in_price, in_quantity, in_clear_first} <= c;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(20);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(5);
          end
        end
      end
    end
  end

  // monitor and receiver stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    book_row_t w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_rows.size() == 0) begin
          report("unexpected result", {45'd0, out_status}, '0);
        end else begin
          w = expected_rows.pop_front();
          if (out_status !== w.status) report("status", out_status, w.status);
          if (out_row_index !== w.row) report("row_index", out_row_index, w.row);
          if (out_bid_valid !== w.bv) report("bid_valid", out_bid_valid, w.bv);
          if (out_bid_price !== w.bp) report("bid_price", out_bid_price, w.bp);
          if (out_bid_size !== w.bs) report("bid_size", out_bid_size, w.bs);
          if (out_ask_valid !== w.av) report("ask_valid", out_ask_valid, w.av);
          if (out_ask_price !== w.ap) report("ask_price", out_ask_price, w.ap);
          if (out_ask_size !== w.as_) report("ask_size", out_ask_size, w.as_);
          if (out_last !== w.last) report("last", out_last, w.last);
        end
      end
      stall_phase = (stall_phase + 1) % 64;
      // quiet stretch in the first quarter, random stalls elsewhere
      out_stall <= stall_phase >= 16 && $urandom_range(3) == 0;
    end
  end

  function automatic book_cmd_t mk(logic [2:0] m, logic sd, logic [47:0] px,
                                   logic [47:0] q, logic cf);
    return {m, sd, px, q, cf};
  endfunction

  // price near a small band so edits hit existing levels often
  function automatic logic [47:0] pick_price();
    case ($urandom_range(9))
      0: return {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
      1: return 48'hFFFF_FFFF_FFFF - $urandom_range(3);
      2: return $urandom_range(3);
      default: return 48'd1000 + $urandom_range(60);
    endcase
  endfunction

  initial begin
    logic [2:0] m;
    logic sd;
    logic [47:0] px;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // directed: empty read, extremes, delete miss, clear_first, undefined modes
    queue_cmd(mk(MODE_READ, 0, 0, 0, 0));
    queue_cmd(mk(MODE_SET, SIDE_BID, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0));
    queue_cmd(mk(MODE_SET, SIDE_BID, 0, 0, 0));
    queue_cmd(mk(MODE_SET, SIDE_ASK, 0, 48'hFFFF_FFFF_FFFF, 1));
    queue_cmd(mk(MODE_SET, SIDE_ASK, 48'hFFFF_FFFF_FFFF, 0, 0));
    queue_cmd(mk(MODE_SET, SIDE_ASK, 0, 48'h5555_5555_5555, 0));
    queue_cmd(mk(MODE_DELETE, SIDE_BID, 48'd77, 0, 0));
    queue_cmd(mk(MODE_DELETE, SIDE_ASK, 48'hFFFF_FFFF_FFFF, 0, 0));
    queue_cmd(mk(MODE_READ, 1, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1));
    queue_cmd(mk(MODE_CHANGE, SIDE_BID, 48'd5, 48'd9, 1));
    queue_cmd(mk(MODE_CHANGE, SIDE_ASK, 48'd7, 48'd3, 0));
    queue_cmd(mk(3'd5, 0, 0, 0, 0));
    queue_cmd(mk(3'd6, 1, 1, 1, 1));
    queue_cmd(mk(3'd7, 0, 0, 0, 0));
    queue_cmd(mk(MODE_READ, 0, 0, 0, 0));
    queue_cmd(mk(MODE_CLEAR, 0, 0, 0, 0));
    // fill both sides past depth to force evictions and drops
    for (int i = 0; i < 36; i++) begin
      queue_cmd(mk(MODE_SET, SIDE_BID, 48'd100 + 2 * i, i, 0));
      queue_cmd(mk(MODE_SET, SIDE_ASK, 48'd300 - 2 * i, i, 0));
    end
    queue_cmd(mk(MODE_SET, SIDE_BID, 48'd1, 1, 0));
    queue_cmd(mk(MODE_SET, SIDE_ASK, 48'd999, 1, 0));
    queue_cmd(mk(MODE_READ, 0, 0, 0, 0));
    wait (pending_cmds.size() < 20);
    hold_for_drain = 1;
    // random part: mostly edits on a narrow price band, regular read outs
    for (int k = 0; k < 290; k++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7: m = MODE_SET;
        8, 9, 10: m = MODE_CHANGE;
        11, 12, 13, 14: m = MODE_DELETE;
        15: m = ($urandom_range(3) == 0) ? MODE_CLEAR : MODE_SET;
        16, 17: m = MODE_READ;
        default: m = ($urandom_range(4) == 0) ? 3'(5 + $urandom_range(2)) : MODE_SET;
      endcase
      sd = $urandom_range(1);
      px = pick_price();
      queue_cmd(mk(m, sd, px, {$urandom, $urandom}, $urandom_range(7) == 0));
      if (k % 40 == 20) wait (pending_cmds.size() < 10);
    end
    queue_cmd(mk(MODE_READ, 0, 0, 0, 0));
    wait (pending_cmds.size() == 0);
    // the last item is on the port now; it drops valid once taken
    @(posedge clk);
    wait (!in_valid);
    wait (expected_rows.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_rows.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #6000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/plb_pkg.sv
rtl/plb_cell.sv
rtl/plb_side.sv
rtl/price_level_order_book.sv
tb/price_level_order_book_tb.sv
